FILE: hw/rtl/rtoq_pkg.sv
// rtoq_pkg: types and codes shared by the rectangle overlap table.
// Used by rect_table_overlap_query_core; no dependencies.
`timescale 1ns / 1ps

package rtoq_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_HIT = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         object_tag;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0]        size_w;
    logic [10:0]        size_h;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] hit_tag;
    logic       status;
    logic       last;
  } out_item_t;

  // one table row, 54 bits
  typedef struct packed {
    logic [7:0]         tag;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [10:0]        w;
    logic [10:0]        h;
  } rect_entry_t;

  localparam int unsigned ENTRY_W = $bits(rect_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

FILE: hw/rtl/rtoq_ram.sv
// rtoq_ram: generic single-write, single-read RAM with registered read data.
// Read data holds while rd_en is low. No dependencies.
`timescale 1ns / 1ps

module rtoq_ram #(
  parameter int unsigned WIDTH  = 54,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/rect_table_overlap_query_core.sv
// rect_table_overlap_query_core: ordered table of tagged rectangles with overlap query.
// Depends on rtoq_pkg and rtoq_ram.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one beat per command (add, remove by tag, overlap query).
//   out_* : result beats; the final beat of each command has last set.
//   Add appends a row (status 1 if the table is full) and returns one ack.
//   Remove deletes every row with the tag, closes the gaps in order, one ack.
//   Query returns one hit beat per overlapping row (own tag skipped, edges
//   inclusive), oldest first, then an end marker.
//   Opcode 3 is dropped without a result.
// Timing:
//   Rows live in a single RAM with registered read data. Scans read one
//   row per cycle, except while a query scan is stalled on a pending hit.
//   One command is in flight at a time; in_ready is high only while idle.
//   The next command is accepted while the final result still sits in
//   the output register.
// Reset: rst_n (synchronous, active low) empties the table; RAM contents are
//   not cleared, rows at or above the count are never read.
// Stall: a blocked out_ready freezes the query scan on the pending hit; the
//   RAM read data holds until the scan moves on.

module rect_table_overlap_query_core
  import rtoq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] wj_r, wj_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    tag_r, tag_nxt;
  logic          status_r, status_nxt;
  logic signed [12:0] left_r, right_r, top_r, bot_r;
  logic signed [12:0] left_nxt, right_nxt, top_nxt, bot_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_free;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  rect_entry_t   wr_data, rd_data;

  logic signed [12:0] e_left, e_right, e_top, e_bot;
  logic hit, keep, last_row, in_fire;

  rtoq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign e_left  = 13'(rd_data.x);
  assign e_top   = 13'(rd_data.y);
  assign e_right = 13'(rd_data.x) + $signed({2'b00, rd_data.w});
  assign e_bot   = 13'(rd_data.y) + $signed({2'b00, rd_data.h});

  assign keep = (rd_data.tag != tag_r);
  assign hit  = keep && !(bot_r < e_top) && !(top_r > e_bot) &&
                !(right_r < e_left) && !(left_r > e_right);
  assign last_row = ((idx_r + CW'(1)) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    wj_r       <= wj_nxt;
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    status_r   <= status_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    wj_nxt        = wj_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    status_nxt    = status_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_data.opcode;
          tag_nxt    = in_data.object_tag;
          status_nxt = 1'b0;
          left_nxt   = 13'(in_data.pos_x);
          top_nxt    = 13'(in_data.pos_y);
          right_nxt  = 13'(in_data.pos_x) + $signed({2'b00, in_data.size_w});
          bot_nxt    = 13'(in_data.pos_y) + $signed({2'b00, in_data.size_h});
          idx_nxt    = '0;
          wj_nxt     = '0;
          case (in_data.opcode)
            OP_ADD: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                status_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_data = '{tag: in_data.object_tag, x: in_data.pos_x,
                            y: in_data.pos_y, w: in_data.size_w, h: in_data.size_h};
                cnt_nxt = cnt_r + CW'(1);
              end
              state_nxt = ST_RESP;
            end
            OP_REMOVE, OP_QUERY: begin
              if (cnt_r == '0) begin
                state_nxt = ST_RESP;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (op_r == OP_REMOVE) begin
          // compact in place: write slot trails read slot
          if (keep) begin
            wr_en   = 1'b1;
            wr_addr = wj_r[AW-1:0];
            wj_nxt  = wj_r + CW'(1);
          end
          if (last_row) begin
            cnt_nxt   = wj_r + CW'(keep);
            state_nxt = ST_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_r + CW'(1));
            idx_nxt = idx_r + CW'(1);
          end
        end else if (!hit || out_free) begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_HIT, hit_tag: rd_data.tag, status: 1'b0,
                              last: 1'b0};
          end
          if (last_row) begin
            state_nxt = ST_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_r + CW'(1));
            idx_nxt = idx_r + CW'(1);
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: (op_r == OP_QUERY) ? KIND_END : KIND_ACK,
                            hit_tag: 8'd0, status: status_r, last: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
